// File: hdl/cbt_pkg.sv
package cbt_pkg;

   // oscillator input and search limits
   localparam logic [22:0] OSC_IN_HZ = 23'd7370000;
   localparam logic [4:0]  Q_FIRST   = 5'd8;
   localparam logic [4:0]  Q_LAST    = 5'd25;
   localparam int          B_BITS    = 6;

   // csr register indexes
   localparam logic [1:0] REG_PLL_FEEDBACK = 2'd0;
   localparam logic [1:0] REG_PLL_POST     = 2'd1;
   localparam logic [1:0] REG_PLL_PRE      = 2'd2;

   // one candidate (quanta, doubling) moving along the search chain
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic              rate_zero;
      logic [4:0]        q;
      logic              dbl;
      logic [25:0]       d;
      logic [32:0]       f2;
      logic [B_BITS-1:0] b;
   } cand_type;

   // candidate with its rate error terms
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic              rate_zero;
      logic [4:0]        q;
      logic              dbl;
      logic [B_BITS-1:0] b;
      logic [32:0]       num;
      logic [11:0]       e;
   } err_type;

   // selection status toward the top level
   typedef struct packed {
      logic              pend;
      logic [B_BITS-1:0] b;
      logic [4:0]        q;
      logic              dbl;
   } res_type;

   // segment split {phase2, phase1, prop} per quanta count
   function automatic logic [8:0] seg_lookup(input logic [4:0] q);
      logic [8:0] s;
      case (q)
         5'd8:    s = {3'd1, 3'd1, 3'd2};
         5'd9:    s = {3'd1, 3'd2, 3'd2};
         5'd10:   s = {3'd2, 3'd2, 3'd2};
         5'd11:   s = {3'd2, 3'd2, 3'd3};
         5'd12:   s = {3'd2, 3'd3, 3'd3};
         5'd13:   s = {3'd3, 3'd3, 3'd3};
         5'd14:   s = {3'd3, 3'd3, 3'd4};
         5'd15:   s = {3'd3, 3'd4, 3'd4};
         5'd16:   s = {3'd4, 3'd4, 3'd4};
         5'd17:   s = {3'd4, 3'd4, 3'd5};
         5'd18:   s = {3'd4, 3'd5, 3'd5};
         5'd19:   s = {3'd5, 3'd5, 3'd5};
         5'd20:   s = {3'd5, 3'd5, 3'd6};
         5'd21:   s = {3'd5, 3'd6, 3'd6};
         5'd22:   s = {3'd6, 3'd6, 3'd6};
         5'd23:   s = {3'd6, 3'd6, 3'd7};
         5'd24:   s = {3'd6, 3'd7, 3'd7};
         5'd25:   s = {3'd7, 3'd7, 3'd7};
         default: s = {3'd1, 3'd1, 3'd2};
      endcase
      return s;
   endfunction

endpackage

// File: hdl/cbt_req_if.sv
interface cbt_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] bit_rate;

   modport source (output valid, output bit_rate, input ready);
   modport sink (input valid, input bit_rate, output ready);
endinterface

// File: hdl/cbt_rsp_if.sv
interface cbt_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] prescaler;
   logic [4:0] quanta_per_bit;
   logic       clock_double;
   logic [2:0] phase2_len;
   logic [2:0] phase1_len;
   logic [2:0] prop_len;

   modport source (output valid, output prescaler, output quanta_per_bit,
                   output clock_double, output phase2_len, output phase1_len,
                   output prop_len, input ready);
   modport sink (input valid, input prescaler, input quanta_per_bit,
                 input clock_double, input phase2_len, input phase1_len,
                 input prop_len, output ready);
endinterface

// File: hdl/cbt_osc_div.sv
module cbt_osc_div
   import cbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [8:0]  pll_feedback,
   input  logic [1:0]  pll_post,
   input  logic [4:0]  pll_pre,
   output logic        busy,
   output logic [30:0] osc_half
);

   logic        load_ff, load_in;
   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [8:0]  rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dividend;
   logic [8:0]  divisor;
   logic [9:0]  shifted;

   // oscillator numerator and pll divider
   assign dividend = 32'(OSC_IN_HZ) * 32'({1'b0, pll_feedback} + 10'd2);
   assign divisor  = 9'({({1'b0, pll_post} + 3'd1), 1'b0}) * 9'({1'b0, pll_pre} + 6'd2);
   assign shifted  = {rem_ff, quo_ff[31]};

   // restoring division, one quotient bit per cycle
   always_comb begin
      load_in = 1'b0;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         load_in = 1'b1;
         busy_in = 1'b1;
      end else if (load_ff) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = 9'(shifted - {1'b0, divisor});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[8:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b1;
         busy_ff <= 1'b1;
      end else begin
         load_ff <= load_in;
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign osc_half = quo_ff[31:1];

endmodule

// File: hdl/cbt_cell.sv
module cbt_cell
   import cbt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic [2:0] bit_idx,
   input  cand_type up_cand,
   output cand_type dn_cand
);

   cand_type              cand_ff, cand_in;
   logic [B_BITS-1:0]     trial;
   logic [32:0]           prod;

   // try one prescaler bit: keep it while 2f > (2t+1)d
   assign trial = up_cand.b | (B_BITS'(1) << bit_idx);
   assign prod  = 33'({trial, 1'b1}) * 33'(up_cand.d);

   always_comb begin
      cand_in = up_cand;
      if (up_cand.f2 > prod) begin
         cand_in.b = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.valid <= 1'b0;
      end else if (en) begin
         cand_ff <= cand_in;
      end
   end

   assign dn_cand = cand_ff;

endmodule

// File: hdl/cbt_select.sv
module cbt_select
   import cbt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  cand_type up_cand,
   output res_type  res
);

   err_type           err_ff, err_in;
   logic [32:0]       re;
   logic [32:0]       f;
   logic [B_BITS-1:0] best_b_ff;
   logic [4:0]        best_q_ff;
   logic              best_dbl_ff;
   logic [32:0]       best_num_ff;
   logic [11:0]       best_e_ff;
   logic [44:0]       lhs;
   logic [44:0]       rhs;
   logic              take;

   // error terms: |d*(b+1) - f| over 2q(b+1)
   assign re = 33'(up_cand.d) * 33'({1'b0, up_cand.b} + 7'd1);
   assign f  = {1'b0, up_cand.f2[32:1]};

   always_comb begin
      err_in.valid     = up_cand.valid;
      err_in.first     = up_cand.first;
      err_in.last      = up_cand.last;
      err_in.rate_zero = up_cand.rate_zero;
      err_in.q         = up_cand.q;
      err_in.dbl       = up_cand.dbl;
      err_in.b         = up_cand.b;
      err_in.num       = (re >= f) ? (re - f) : (f - re);
      err_in.e         = 12'({up_cand.q, 1'b0}) * 12'({1'b0, up_cand.b} + 7'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff.valid <= 1'b0;
      end else if (en) begin
         err_ff <= err_in;
      end
   end

   // exact compare by cross products, first strictly smaller wins
   assign lhs  = 45'(err_ff.num) * 45'(best_e_ff);
   assign rhs  = 45'(best_num_ff) * 45'(err_ff.e);
   assign take = err_ff.valid && (err_ff.first || (!err_ff.rate_zero && (lhs < rhs)));

   always_ff @(posedge clock) begin
      if (en && take) begin
         best_b_ff   <= err_ff.b;
         best_q_ff   <= err_ff.q;
         best_dbl_ff <= err_ff.dbl;
         best_num_ff <= err_ff.num;
         best_e_ff   <= err_ff.e;
      end
   end

   assign res.pend = err_ff.valid && err_ff.last;
   assign res.b    = take ? err_ff.b   : best_b_ff;
   assign res.q    = take ? err_ff.q   : best_q_ff;
   assign res.dbl  = take ? err_ff.dbl : best_dbl_ff;

endmodule

// File: hdl/can_bit_timing_search.sv
// each input yields 36 candidates, passing 8 stages (generator register,
// prescaler cells, error register) on their way to the output register;
// the candidate generator issues one (quanta, doubling) pair per cycle into the
// search chain unless it stalls, and keeps req ready low until the last is out
// reset: pll registers take their defaults and the oscillator is divided again,
// which holds req ready low until the divide ends; every csr write does the same
module can_bit_timing_search
   import cbt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   cbt_req_if.sink           req_chan,
   cbt_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [8:0]        csr_wdata
);

   logic [8:0]  fb_ff;
   logic [1:0]  post_ff;
   logic [4:0]  pre_ff;
   logic        osc_busy;
   logic [30:0] osc_half;

   logic        gen_busy_ff, gen_busy_in;
   logic        gen_first_ff, gen_first_in;
   logic [19:0] gen_rate_ff, gen_rate_in;
   logic [4:0]  gen_q_ff, gen_q_in;
   logic        gen_dbl_ff, gen_dbl_in;
   logic        gen_last;
   cand_type    gen_cand_ff, gen_cand_in;

   cand_type    chain [B_BITS+1];
   res_type     res;
   logic        en;
   logic        done;
   logic        req_take;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [B_BITS-1:0] rsp_b_ff;
   logic [4:0]        rsp_q_ff;
   logic              rsp_dbl_ff;
   logic [8:0]        seg;

   // pll registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff   <= 9'd48;
         post_ff <= 2'd1;
         pre_ff  <= 5'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_PLL_FEEDBACK: fb_ff   <= csr_wdata;
            REG_PLL_POST:     post_ff <= csr_wdata[1:0];
            REG_PLL_PRE:      pre_ff  <= csr_wdata[4:0];
            default:          ;
         endcase
      end
   end

   cbt_osc_div u_osc_div (
      .clock        (clock),
      .reset        (reset),
      .start        (csr_we),
      .pll_feedback (fb_ff),
      .pll_post     (post_ff),
      .pll_pre      (pre_ff),
      .busy         (osc_busy),
      .osc_half     (osc_half)
   );

   // chain stalls only when a finished item meets a full output register not being read
   assign en       = !(res.pend && rsp_valid_ff && !rsp_chan.ready);
   assign done     = en && res.pend;
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !gen_busy_ff && !osc_busy;

   // candidate generator, quanta outer and doubling inner
   assign gen_last = (gen_q_ff == Q_LAST) && gen_dbl_ff;

   always_comb begin
      gen_busy_in  = gen_busy_ff;
      gen_first_in = gen_first_ff;
      gen_rate_in  = gen_rate_ff;
      gen_q_in     = gen_q_ff;
      gen_dbl_in   = gen_dbl_ff;
      gen_cand_in  = gen_cand_ff;
      if (en) begin
         gen_cand_in.valid     = gen_busy_ff;
         gen_cand_in.first     = gen_first_ff;
         gen_cand_in.last      = gen_last;
         gen_cand_in.rate_zero = (gen_rate_ff == 20'd0);
         gen_cand_in.q         = gen_q_ff;
         gen_cand_in.dbl       = gen_dbl_ff;
         gen_cand_in.d         = 26'({gen_q_ff, 1'b0}) * 26'(gen_rate_ff);
         gen_cand_in.f2        = gen_dbl_ff ? {osc_half, 2'b00} : {1'b0, osc_half, 1'b0};
         gen_cand_in.b         = '0;
         if (gen_busy_ff) begin
            gen_first_in = 1'b0;
            gen_dbl_in   = !gen_dbl_ff;
            if (gen_dbl_ff) begin
               gen_q_in = gen_q_ff + 5'd1;
            end
            if (gen_last) begin
               gen_busy_in = 1'b0;
            end
         end
      end
      if (req_take) begin
         gen_busy_in  = 1'b1;
         gen_first_in = 1'b1;
         gen_rate_in  = req_chan.bit_rate;
         gen_q_in     = Q_FIRST;
         gen_dbl_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_busy_ff       <= 1'b0;
         gen_cand_ff.valid <= 1'b0;
      end else begin
         gen_busy_ff <= gen_busy_in;
         gen_cand_ff <= gen_cand_in;
      end
      gen_first_ff <= gen_first_in;
      gen_rate_ff  <= gen_rate_in;
      gen_q_ff     <= gen_q_in;
      gen_dbl_ff   <= gen_dbl_in;
   end

   // prescaler search, one bit per cell from the top bit down
   assign chain[0] = gen_cand_ff;

   for (genvar i = 0; i < B_BITS; i++) begin : g_cell
      cbt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .bit_idx (3'(B_BITS - 1 - i)),
         .up_cand (chain[i]),
         .dn_cand (chain[i+1])
      );
   end

   cbt_select u_select (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .up_cand (chain[B_BITS]),
      .res     (res)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done) begin
         rsp_b_ff   <= res.b;
         rsp_q_ff   <= res.q;
         rsp_dbl_ff <= res.dbl;
      end
   end

   assign seg = seg_lookup(rsp_q_ff);

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.prescaler      = rsp_b_ff;
   assign rsp_chan.quanta_per_bit = rsp_q_ff;
   assign rsp_chan.clock_double   = rsp_dbl_ff;
   assign rsp_chan.phase2_len     = seg[8:6];
   assign rsp_chan.phase1_len     = seg[5:3];
   assign rsp_chan.prop_len       = seg[2:0];

   // generator stays within the quanta range while issuing
   a_gen_q_range: assert property (@(posedge clock) disable iff (reset)
      gen_busy_ff |-> (gen_q_ff >= Q_FIRST && gen_q_ff <= Q_LAST))
      else $error("generator quanta out of range");

   // the last candidate leaves the generator idle
   a_gen_last_idle: assert property (@(posedge clock) disable iff (reset)
      (gen_busy_ff && en && gen_last && !req_take) |=> !gen_busy_ff)
      else $error("generator still busy after last candidate");

   // a delivered result carries a searched quanta count
   a_rsp_q_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_q_ff >= Q_FIRST && rsp_q_ff <= Q_LAST))
      else $error("result quanta out of range");

   // no item enters while the oscillator divide runs
   a_no_take_osc: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!osc_busy && !gen_busy_ff))
      else $error("transfer accepted during oscillator divide");

endmodule
